### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
// Needs a signal named clock and an active-high signal named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high
`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/rar_pkg.sv
// Types and codes of the rational arithmetic block.
// No dependencies; used by the controller, datapath, top level and checker.
package rar_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MUL_NUM,
      MUL_AUX,
      MUL_DEN
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_GCD,
      DIV_NUM,
      DIV_DEN,
      DIV_WHOLE
   } div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_MUL_NUM,
      S_MUL_AUX,
      S_MUL_DEN,
      S_CHKDEN,
      S_GCD,
      S_GCD_WAIT,
      S_DIV_NUM,
      S_DIV_DEN,
      S_CHKFIT,
      S_WHOLE,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        sum_eq;
      logic        sum_cross;
      logic        gcd_init;
      logic        div_go;
      div_sel_type div_sel;
      logic        out_load;
      status_type  out_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic   in_den_zero;
      logic   eq_den;
      op_type op;
      logic   den_zero;
      logic   y_zero;
      logic   mul_done;
      logic   div_done;
      logic   nd_fit;
      logic   whole_fit;
   } sts_type;

endpackage

### rtl/core/rar_ctrl.sv
// Sequencer of the rational arithmetic block: products, sum, Euclid loop,
// reductions and result handoff. Depends on rar_pkg.
module rar_ctrl
   import rar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       addsub;

   assign addsub     = (sts.op == OP_ADD) || (sts.op == OP_SUB);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               status_in = ST_OK;
               state_in  = S_START;
            end
         end
         S_START: begin
            if (sts.in_den_zero) begin
               status_in = ST_ZERO_DEN;
               state_in  = S_FINISH;
            end else if (addsub && sts.eq_den) begin
               cmd.sum_eq = 1'b1;
               state_in   = S_CHKDEN;
            end else begin
               cmd.mul_go  = 1'b1;
               cmd.mul_sel = MUL_NUM;
               state_in    = S_MUL_NUM;
            end
         end
         S_MUL_NUM: begin
            if (sts.mul_done) begin
               cmd.mul_go = 1'b1;
               if (addsub) begin
                  cmd.mul_sel = MUL_AUX;
                  state_in    = S_MUL_AUX;
               end else begin
                  cmd.mul_sel = MUL_DEN;
                  state_in    = S_MUL_DEN;
               end
            end
         end
         S_MUL_AUX: begin
            if (sts.mul_done) begin
               cmd.mul_go  = 1'b1;
               cmd.mul_sel = MUL_DEN;
               state_in    = S_MUL_DEN;
            end
         end
         S_MUL_DEN: begin
            if (sts.mul_done) begin
               cmd.sum_cross = addsub;
               state_in      = S_CHKDEN;
            end
         end
         S_CHKDEN: begin
            if (sts.den_zero) begin
               status_in = ST_ZERO_DEN;
               state_in  = S_FINISH;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = S_GCD;
            end
         end
         S_GCD: begin
            cmd.div_go = 1'b1;
            if (sts.y_zero) begin
               cmd.div_sel = DIV_NUM;
               state_in    = S_DIV_NUM;
            end else begin
               cmd.div_sel = DIV_GCD;
               state_in    = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (sts.div_done) state_in = S_GCD;
         end
         S_DIV_NUM: begin
            if (sts.div_done) begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = DIV_DEN;
               state_in    = S_DIV_DEN;
            end
         end
         S_DIV_DEN: begin
            if (sts.div_done) state_in = S_CHKFIT;
         end
         S_CHKFIT: begin
            if (!sts.nd_fit) begin
               status_in = ST_OVERFLOW;
               state_in  = S_FINISH;
            end else begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = DIV_WHOLE;
               state_in    = S_WHOLE;
            end
         end
         S_WHOLE: begin
            if (sts.div_done) begin
               status_in = sts.whole_fit ? ST_OK : ST_OVERFLOW;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = status_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output beat flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/rar_datapath.sv
// Datapath of the rational arithmetic block: sign-magnitude operands,
// bit-serial multiplier, restoring divider, Euclid registers, result register.
// Depends on rar_pkg.
module rar_datapath
   import rar_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  op_type               operation,
   input  logic [WORD_BITS-1:0] a_numerator,
   input  logic [WORD_BITS-1:0] a_denominator,
   input  logic [WORD_BITS-1:0] b_numerator,
   input  logic [WORD_BITS-1:0] b_denominator,
   output logic [WORD_BITS-1:0] result_numerator,
   output logic [WORD_BITS-1:0] result_denominator,
   output logic [WORD_BITS-1:0] whole_part,
   output status_type           status
);

   localparam int W  = WORD_BITS;
   localparam int M  = 2 * WORD_BITS;
   localparam int CW = $clog2(M + 1);
   localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

   function automatic logic fits(input logic s, input logic [M-1:0] m);
      return (m[M-1:W] == '0) && (s ? (m[W-1:0] <= HALF) : (m[W-1:0] < HALF));
   endfunction

   function automatic logic [W-1:0] to_bits(input logic s, input logic [M-1:0] m);
      logic [W-1:0] l;
      l = m[W-1:0];
      return s ? (~l + 1'b1) : l;
   endfunction

   // operands
   op_type       op_ff, op_in;
   logic         an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff, ae_s_ff;
   logic         an_s_in, ad_s_in, bn_s_in, bd_s_in, ae_s_in;
   logic [W-1:0] an_m_ff, ad_m_ff, bn_m_ff, bd_m_ff;
   logic [W-1:0] an_m_in, ad_m_in, bn_m_in, bd_m_in;
   logic         dz_ff, dz_in, eq_ff, eq_in;
   // formed fraction, products and Euclid pair
   logic         num_s_ff, den_s_ff, aux_s_ff, x_s_ff, y_s_ff, whole_s_ff;
   logic         num_s_in, den_s_in, aux_s_in, x_s_in, y_s_in, whole_s_in;
   logic [M-1:0] num_m_ff, den_m_ff, aux_m_ff, x_m_ff, y_m_ff, whole_m_ff;
   logic [M-1:0] num_m_in, den_m_in, aux_m_in, x_m_in, y_m_in, whole_m_in;
   // serial multiplier
   logic         mul_run_ff, mul_run_in, mul_done_ff, mul_done_in, mul_s_ff, mul_s_in;
   mul_sel_type  mul_sel_ff, mul_sel_in;
   logic [M-1:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [W-1:0] mplr_ff, mplr_in;
   // serial divider
   logic         div_run_ff, div_run_in, div_done_ff, div_done_in;
   div_sel_type  div_sel_ff, div_sel_in;
   logic [M-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // result register
   logic [W-1:0] rn_ff, rn_in, rd_ff, rd_in, rw_ff, rw_in;
   status_type   rs_ff, rs_in;

   // working signals
   logic         pa_s, pb_s, sa_s, sb_s, sr_s;
   logic [W-1:0] pa_m, pb_m;
   logic [M-1:0] sa_m, sb_m, sr_m, acc_nx, rem_nx, quo_nx, dn_m, dd_m;
   logic [M:0]   rsh, rdiff;
   logic         rge;

   // multiplier operand select
   always_comb begin
      case (mul_sel_in)
         MUL_NUM: begin
            pa_s = an_s_ff; pa_m = an_m_ff;
            pb_s = (op_ff == OP_MUL) ? bn_s_ff : bd_s_ff;
            pb_m = (op_ff == OP_MUL) ? bn_m_ff : bd_m_ff;
         end
         MUL_AUX: begin
            pa_s = ae_s_ff; pa_m = bn_m_ff;
            pb_s = ad_s_ff; pb_m = ad_m_ff;
         end
         default: begin
            pa_s = ad_s_ff; pa_m = ad_m_ff;
            pb_s = (op_ff == OP_DIV) ? bn_s_ff : bd_s_ff;
            pb_m = (op_ff == OP_DIV) ? bn_m_ff : bd_m_ff;
         end
      endcase
   end

   // signed adder for the formed numerator
   always_comb begin
      if (cmd.sum_eq) begin
         sa_s = an_s_ff; sa_m = M'(an_m_ff);
         sb_s = ae_s_ff; sb_m = M'(bn_m_ff);
      end else begin
         sa_s = num_s_ff; sa_m = num_m_ff;
         sb_s = aux_s_ff; sb_m = aux_m_ff;
      end
      if (sa_s == sb_s) begin
         sr_m = sa_m + sb_m; sr_s = sa_s;
      end else if (sa_m >= sb_m) begin
         sr_m = sa_m - sb_m; sr_s = sa_s;
      end else begin
         sr_m = sb_m - sa_m; sr_s = sb_s;
      end
   end

   // one multiplier and one divider step
   assign acc_nx = acc_ff + (mplr_ff[0] ? mcand_ff : '0);
   assign rsh    = {rem_ff, quo_ff[M-1]};
   assign rdiff  = rsh - {1'b0, dvs_ff};
   assign rge    = (rsh >= {1'b0, dvs_ff});
   assign rem_nx = rge ? rdiff[M-1:0] : rsh[M-1:0];
   assign quo_nx = {quo_ff[M-2:0], rge};

   // divider operand select
   always_comb begin
      case (cmd.div_sel)
         DIV_GCD:   begin dn_m = x_m_ff;   dd_m = y_m_ff;   end
         DIV_NUM:   begin dn_m = num_m_ff; dd_m = x_m_ff;   end
         DIV_DEN:   begin dn_m = den_m_ff; dd_m = x_m_ff;   end
         default:   begin dn_m = num_m_ff; dd_m = den_m_ff; end
      endcase
   end

   // next values
   always_comb begin
      op_in = op_ff;
      an_s_in = an_s_ff; ad_s_in = ad_s_ff; bn_s_in = bn_s_ff; bd_s_in = bd_s_ff;
      ae_s_in = ae_s_ff;
      an_m_in = an_m_ff; ad_m_in = ad_m_ff; bn_m_in = bn_m_ff; bd_m_in = bd_m_ff;
      dz_in = dz_ff; eq_in = eq_ff;
      num_s_in = num_s_ff; den_s_in = den_s_ff; aux_s_in = aux_s_ff;
      x_s_in = x_s_ff; y_s_in = y_s_ff; whole_s_in = whole_s_ff;
      num_m_in = num_m_ff; den_m_in = den_m_ff; aux_m_in = aux_m_ff;
      x_m_in = x_m_ff; y_m_in = y_m_ff; whole_m_in = whole_m_ff;
      mul_run_in = mul_run_ff; mul_done_in = 1'b0; mul_s_in = mul_s_ff;
      mul_sel_in = mul_sel_ff;
      mcand_in = mcand_ff; acc_in = acc_ff; mplr_in = mplr_ff;
      div_run_in = div_run_ff; div_done_in = 1'b0; div_sel_in = div_sel_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      rn_in = rn_ff; rd_in = rd_ff; rw_in = rw_ff; rs_in = rs_ff;

      if (cmd.mul_go) mul_sel_in = cmd.mul_sel;

      // capture input beat as sign and magnitude
      if (cmd.load) begin
         op_in   = operation;
         an_s_in = a_numerator[W-1];
         ad_s_in = a_denominator[W-1];
         bn_s_in = b_numerator[W-1];
         bd_s_in = b_denominator[W-1];
         an_m_in = a_numerator[W-1]   ? (~a_numerator + 1'b1)   : a_numerator;
         ad_m_in = a_denominator[W-1] ? (~a_denominator + 1'b1) : a_denominator;
         bn_m_in = b_numerator[W-1]   ? (~b_numerator + 1'b1)   : b_numerator;
         bd_m_in = b_denominator[W-1] ? (~b_denominator + 1'b1) : b_denominator;
         // subtract adds the negated second numerator; zero stays positive
         ae_s_in = (operation == OP_SUB) ? (!b_numerator[W-1] && (b_numerator != '0))
                                         : b_numerator[W-1];
         dz_in   = (a_denominator == '0) || (b_denominator == '0);
         eq_in   = (a_denominator == b_denominator);
      end

      // product start and steps
      if (cmd.mul_go) begin
         mul_run_in = 1'b1;
         mul_s_in   = pa_s ^ pb_s;
         mcand_in   = M'(pa_m);
         mplr_in    = pb_m;
         acc_in     = '0;
         cnt_in     = CW'(W);
      end else if (mul_run_ff) begin
         acc_in   = acc_nx;
         mcand_in = {mcand_ff[M-2:0], 1'b0};
         mplr_in  = {1'b0, mplr_ff[W-1:1]};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            mul_run_in  = 1'b0;
            mul_done_in = 1'b1;
            case (mul_sel_ff)
               MUL_NUM: begin num_m_in = acc_nx; num_s_in = mul_s_ff && (acc_nx != '0); end
               MUL_AUX: begin aux_m_in = acc_nx; aux_s_in = mul_s_ff && (acc_nx != '0); end
               default: begin den_m_in = acc_nx; den_s_in = mul_s_ff && (acc_nx != '0); end
            endcase
         end
      end

      // formed numerator
      if (cmd.sum_eq || cmd.sum_cross) begin
         num_m_in = sr_m;
         num_s_in = sr_s && (sr_m != '0);
      end
      if (cmd.sum_eq) begin
         den_m_in = M'(ad_m_ff);
         den_s_in = ad_s_ff;
      end

      if (cmd.gcd_init) begin
         x_s_in = num_s_ff; x_m_in = num_m_ff;
         y_s_in = den_s_ff; y_m_in = den_m_ff;
      end

      // division start and steps
      if (cmd.div_go) begin
         div_run_in = 1'b1;
         div_sel_in = cmd.div_sel;
         quo_in     = dn_m;
         dvs_in     = dd_m;
         rem_in     = '0;
         cnt_in     = CW'(M);
      end else if (div_run_ff) begin
         quo_in = quo_nx;
         rem_in = rem_nx;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            div_run_in  = 1'b0;
            div_done_in = 1'b1;
            case (div_sel_ff)
               DIV_GCD: begin
                  x_s_in = y_s_ff; x_m_in = y_m_ff;
                  y_m_in = rem_nx; y_s_in = x_s_ff && (rem_nx != '0);
               end
               DIV_NUM: begin
                  num_m_in = quo_nx; num_s_in = (num_s_ff ^ x_s_ff) && (quo_nx != '0);
               end
               DIV_DEN: begin
                  den_m_in = quo_nx; den_s_in = (den_s_ff ^ x_s_ff) && (quo_nx != '0);
               end
               default: begin
                  whole_m_in = quo_nx;
                  whole_s_in = (num_s_ff ^ den_s_ff) && (quo_nx != '0);
               end
            endcase
         end
      end

      // result register, zeroed on error
      if (cmd.out_load) begin
         rs_in = cmd.out_status;
         if (cmd.out_status == ST_OK) begin
            rn_in = to_bits(num_s_ff, num_m_ff);
            rd_in = to_bits(den_s_ff, den_m_ff);
            rw_in = to_bits(whole_s_ff, whole_m_ff);
         end else begin
            rn_in = '0; rd_in = '0; rw_in = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_run_ff  <= 1'b0;
         mul_done_ff <= 1'b0;
         div_run_ff  <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         mul_run_ff  <= mul_run_in;
         mul_done_ff <= mul_done_in;
         div_run_ff  <= div_run_in;
         div_done_ff <= div_done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      an_s_ff <= an_s_in; ad_s_ff <= ad_s_in; bn_s_ff <= bn_s_in; bd_s_ff <= bd_s_in;
      ae_s_ff <= ae_s_in;
      an_m_ff <= an_m_in; ad_m_ff <= ad_m_in; bn_m_ff <= bn_m_in; bd_m_ff <= bd_m_in;
      dz_ff <= dz_in; eq_ff <= eq_in;
      num_s_ff <= num_s_in; den_s_ff <= den_s_in; aux_s_ff <= aux_s_in;
      x_s_ff <= x_s_in; y_s_ff <= y_s_in; whole_s_ff <= whole_s_in;
      num_m_ff <= num_m_in; den_m_ff <= den_m_in; aux_m_ff <= aux_m_in;
      x_m_ff <= x_m_in; y_m_ff <= y_m_in; whole_m_ff <= whole_m_in;
      mul_s_ff <= mul_s_in; mul_sel_ff <= mul_sel_in;
      mcand_ff <= mcand_in; acc_ff <= acc_in; mplr_ff <= mplr_in;
      div_sel_ff <= div_sel_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      rn_ff <= rn_in; rd_ff <= rd_in; rw_ff <= rw_in; rs_ff <= rs_in;
   end

   // status to controller
   assign sts.in_den_zero = dz_ff;
   assign sts.eq_den      = eq_ff;
   assign sts.op          = op_ff;
   assign sts.den_zero    = (den_m_ff == '0);
   assign sts.y_zero      = (y_m_ff == '0);
   assign sts.mul_done    = mul_done_ff;
   assign sts.div_done    = div_done_ff;
   assign sts.nd_fit      = fits(num_s_ff, num_m_ff) && fits(den_s_ff, den_m_ff);
   assign sts.whole_fit   = fits(whole_s_ff, whole_m_ff);

   assign result_numerator   = rn_ff;
   assign result_denominator = rd_ff;
   assign whole_part         = rw_ff;
   assign status             = rs_ff;

endmodule

### rtl/core/rational_arith_reduce.sv
// Exact add, subtract, multiply or divide of two signed fractions, reduced by
// Euclid's gcd with truncating remainder (the sign may end up in the
// denominator), plus the truncated whole part. One item is in work at a time;
// a new beat is taken while a finished result still waits on the output.
// Result valid rises in the same cycle as the input opens again. A request
// takes 2 or 3 products (none when add/subtract see equal denominators) and
// up to about 2.9*WORD_BITS Euclid steps; the bit-serial multiplier and the
// restoring divider each retire one bit a cycle. Zero input denominators skip
// the products and the Euclid loop and go straight to the error result.
// Depends on rar_pkg, rar_ctrl and rar_datapath.
module rational_arith_reduce
   import rar_pkg::*;
#(
   parameter int WORD_BITS = 32,
   localparam int IN_W  = ((4 * WORD_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((3 * WORD_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // a_numerator, a_denominator, b_numerator, b_denominator
   input  logic [IN_W-1:0]  req_tdata,
   // operation
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // result_numerator, result_denominator, whole_part
   output logic [OUT_W-1:0] rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser
);

   localparam int W = WORD_BITS;

   cmd_type      cmd;
   sts_type      sts;
   logic [W-1:0] r_num, r_den, r_whole;
   status_type   r_status;

   rar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rar_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .operation          (op_type'(req_tuser)),
      .a_numerator        (req_tdata[W-1:0]),
      .a_denominator      (req_tdata[2*W-1:W]),
      .b_numerator        (req_tdata[3*W-1:2*W]),
      .b_denominator      (req_tdata[4*W-1:3*W]),
      .result_numerator   (r_num),
      .result_denominator (r_den),
      .whole_part         (r_whole),
      .status             (r_status)
   );

   assign rsp_tdata = OUT_W'({r_whole, r_den, r_num});
   assign rsp_tuser = r_status;

endmodule

### rtl/core/rar_checker.sv
// Port-level checks of rational_arith_reduce, bound to the top level.
// Depends on rar_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rar_checker
   import rar_pkg::*;
#(
   parameter int WORD_BITS = 32,
   localparam int IN_W  = ((4 * WORD_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((3 * WORD_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [IN_W-1:0]  req_tdata,
   input logic [1:0]       req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata,
   input logic [1:0]       rsp_tuser
);

   logic                 rsp_stall;
   logic [OUT_W+1:0]     rsp_beat;
   logic [WORD_BITS-1:0] rsp_den;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat  = {rsp_tuser, rsp_tdata};
   assign rsp_den   = rsp_tdata[2*WORD_BITS-1:WORD_BITS];

   // a stalled result beat holds
   `ASSERT_CLK(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_beat), "stalled beat changed")
   // one item in work: input closes after a beat
   `ASSERT_CLK(a_one_item, req_tvalid && req_tready |=> !req_tready, "input open after a beat")
   // error results carry zero data
   `ASSERT_CLK(a_err_zero, rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0, "error with data")
   // good results have a nonzero denominator
   `ASSERT_CLK(a_den_nz, rsp_tvalid && (rsp_tuser == ST_OK) |-> rsp_den != '0, "ok with zero den")
   // no result beat right after reset
   `ASSERT_RST(a_rst_quiet, reset |=> !rsp_tvalid, "result beat after reset")

endmodule

bind rational_arith_reduce rar_checker #(.WORD_BITS(WORD_BITS)) u_rar_checker (.*);

### bench/rational_arith_reduce_check.sv
// Scoreboard for rational_arith_reduce: watches both stream channels, predicts
// each reduced fraction from the accepted request beat and compares results.
// Depends on rar_pkg for the operation and status codes.
`timescale 1ns / 100ps

module rational_arith_reduce_check
   import rar_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   // a_numerator, a_denominator, b_numerator, b_denominator
   input  logic [127:0]       req_tdata,
   // operation
   input  logic [1:0]         req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   // result_numerator, result_denominator, whole_part
   input  logic [95:0]        rsp_tdata,
   // status
   input  logic [1:0]         rsp_tuser,
   output int unsigned        errors,
   output int unsigned        pending
);

   // sign plus exact magnitude, zero never negative
   typedef struct packed {
      logic         neg;
      logic [127:0] mag;
   } exact_type;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] whole;
      status_type  status;
   } fraction_type;

   fraction_type reduced_q[$];

   function automatic exact_type mk(logic neg, logic [127:0] mag);
      exact_type v;
      v.neg = (mag == 0) ? 1'b0 : neg;
      v.mag = mag;
      return v;
   endfunction

   function automatic exact_type from_word(logic [31:0] w);
      logic [31:0] m;
      m = w[31] ? (~w + 32'd1) : w;
      return mk(w[31], {96'b0, m});
   endfunction

   function automatic exact_type ex_add(exact_type a, exact_type b);
      if (a.neg == b.neg) return mk(a.neg, a.mag + b.mag);
      if (a.mag >= b.mag) return mk(a.neg, a.mag - b.mag);
      return mk(b.neg, b.mag - a.mag);
   endfunction

   function automatic exact_type ex_mul(exact_type a, exact_type b);
      return mk(a.neg != b.neg, a.mag * b.mag);
   endfunction

   function automatic exact_type ex_quo(exact_type a, exact_type b);
      return mk(a.neg != b.neg, a.mag / b.mag);
   endfunction

   function automatic logic ex_fits(exact_type a);
      return a.neg ? (a.mag <= 128'h8000_0000) : (a.mag <= 128'h7FFF_FFFF);
   endfunction

   function automatic logic [31:0] ex_word(exact_type a);
      logic [127:0] t;
      t = a.neg ? -a.mag : a.mag;
      return t[31:0];
   endfunction

   // exact result of one request, reduced by truncating-remainder gcd
   function automatic fraction_type reduce_fraction(op_type op, logic [127:0] d);
      fraction_type r;
      exact_type an, ad, bn, bd, addend, num, den, x, y, t, whole;
      r = '{num: '0, den: '0, whole: '0, status: ST_ZERO_DEN};
      an = from_word(d[31:0]);
      ad = from_word(d[63:32]);
      bn = from_word(d[95:64]);
      bd = from_word(d[127:96]);
      if (ad.mag == 0 || bd.mag == 0) return r;
      case (op)
         OP_ADD, OP_SUB: begin
            addend = (op == OP_ADD) ? bn : mk(!bn.neg, bn.mag);
            if (ad == bd) begin
               num = ex_add(an, addend);
               den = ad;
            end else begin
               num = ex_add(ex_mul(an, bd), ex_mul(addend, ad));
               den = ex_mul(ad, bd);
            end
         end
         OP_MUL: begin
            num = ex_mul(an, bn);
            den = ex_mul(ad, bd);
         end
         default: begin
            num = ex_mul(an, bd);
            den = ex_mul(ad, bn);
         end
      endcase
      if (den.mag == 0) return r;
      x = num;
      y = den;
      while (y.mag != 0) begin
         t = y;
         y = mk(x.neg, x.mag % y.mag);
         x = t;
      end
      num = ex_quo(num, x);
      den = ex_quo(den, x);
      r.status = ST_OVERFLOW;
      if (!ex_fits(num) || !ex_fits(den)) return r;
      whole = ex_quo(num, den);
      if (!ex_fits(whole)) return r;
      r.num = ex_word(num);
      r.den = ex_word(den);
      r.whole = ex_word(whole);
      r.status = ST_OK;
      return r;
   endfunction

   assign pending = reduced_q.size();

   // request beats feed the prediction queue
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         reduced_q.push_back(reduce_fraction(op_type'(req_tuser), req_tdata));
   end

   // result beats are checked against the oldest prediction
   initial errors = 0;
   always @(posedge clock) begin
      fraction_type exp_r, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{num: rsp_tdata[31:0], den: rsp_tdata[63:32],
                 whole: rsp_tdata[95:64], status: status_type'(rsp_tuser)};
         if (reduced_q.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10) $display("unexpected result beat %h", got);
         end else begin
            exp_r = reduced_q.pop_front();
            if (got !== exp_r) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("mismatch: expected num %h den %h whole %h st %0d, got %h %h %h %0d",
                           exp_r.num, exp_r.den, exp_r.whole, exp_r.status,
                           got.num, got.den, got.whole, got.status);
            end
         end
      end
   end

endmodule

### bench/rational_arith_reduce_test.sv
// Top of the rational_arith_reduce bench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Needs rar_pkg, the block and
// rational_arith_reduce_check.
`timescale 1ns / 100ps

module rational_arith_reduce_test;
   import rar_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = OP_ADD;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   int unsigned  errors, pending;
   int unsigned  tx_idle = 0, rx_idle = 0;
   int unsigned  quiet = 0;

   always #6 clock = ~clock;

   rational_arith_reduce DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   rational_arith_reduce_check scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .errors(errors), .pending(pending)
   );

   // receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle);

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one request beat, with random gaps before it
   task automatic send_fraction(op_type op, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {bd, bn, ad, an};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0, 1, 2, 3: return 32'($signed($urandom_range(40)) - 20);
         4: return 32'h8000_0000;
         5: return 32'h7FFF_FFFF;
         6: return 32'($urandom_range(65535)) << $urandom_range(16);
         default: return $urandom;
      endcase
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] ad, bd;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each operation, zero denominators, overflow
      send_fraction(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      send_fraction(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
      send_fraction(OP_MUL, -32'd2, 32'd3, 32'd9, -32'd4);
      send_fraction(OP_DIV, 32'd5, 32'd7, -32'd10, 32'd21);
      send_fraction(OP_ADD, 32'd3, 32'd4, 32'd5, 32'd4);       // shared denominator
      send_fraction(OP_SUB, 32'd3, -32'd6, 32'd5, -32'd6);     // shared negative den
      send_fraction(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);       // zero a denominator
      send_fraction(OP_SUB, 32'd1, 32'd1, 32'd1, 32'd0);       // zero b denominator
      send_fraction(OP_DIV, 32'd7, 32'd3, 32'd0, 32'd5);       // divide by zero fraction
      send_fraction(OP_MUL, 32'd0, 32'd9, 32'd4, 32'd5);       // zero numerator
      send_fraction(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
      send_fraction(OP_DIV, 32'h8000_0000, 32'd1, -32'd1, 32'd1);
      send_fraction(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
      send_fraction(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000);
      send_fraction(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h8000_0000);
      send_fraction(OP_MUL, 32'h8000_0000, -32'd1, 32'd1, 32'd1);
      send_fraction(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000);
      send_fraction(OP_DIV, 32'd0, 32'd1, 32'd0, 32'd1);
      drain();

      // random phases with changing idle ratios
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
         rx_idle = (phase == 0) ? 87 : (phase == 1) ? 31 : 0;
         for (int n = 0; n < 500; n++) begin
            ad = rand_word();
            bd = ($urandom_range(6) == 0) ? ad : rand_word();
            send_fraction(op_type'($urandom_range(3)), rand_word(), ad, rand_word(), bd);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
